// ----- rtl/ffr_pkg.sv -----
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants for the flag delimited frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 9;
  localparam int unsigned StatW  = 3;
  localparam int unsigned RegIdxW = 2;

  localparam logic [ByteW-1:0] StartFlagRst = 8'h69;
  localparam logic [ByteW-1:0] EndFlagRst   = 8'h96;
  localparam logic [PosW-1:0]  MaxFrameRst  = 9'd200;

  // start flag, opcode, length, checksum, end flag
  localparam logic [PosW-1:0] FrameOverhead = 9'd5;

  localparam logic [PosW-1:0] PosStart  = 9'd0;
  localparam logic [PosW-1:0] PosOpcode = 9'd1;
  localparam logic [PosW-1:0] PosLength = 9'd2;
  localparam logic [PosW-1:0] PosMax    = 9'd259;

  localparam logic [RegIdxW-1:0] RegStartFlag = 2'd0;
  localparam logic [RegIdxW-1:0] RegEndFlag   = 2'd1;
  localparam logic [RegIdxW-1:0] RegMaxFrame  = 2'd2;

  typedef enum logic [StatW-1:0] {
    ST_DISCARD = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_DONE    = 3'd2,
    ST_BAD_END = 3'd3,
    ST_BAD_LEN = 3'd4
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] sof_byte;
    logic [ByteW-1:0] eof_byte;
    logic [PosW-1:0]  max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] data_byte;
    logic [PosW-1:0]  position;
  } res_t;

endpackage

// ----- rtl/ffr_core.sv -----
// ----------------------------------------------------------------------------
// ffr_core
// Frame position tracking and per-byte classification.
// ----------------------------------------------------------------------------
module ffr_core
  import ffr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  logic [PosW-1:0]  count_q, count_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [PosW-1:0]  last_pos;
  logic [PosW-1:0]  frame_size;

  assign last_pos   = {1'b0, len_q} + FrameOverhead - 9'd1;
  assign frame_size = {1'b0, rx_byte_i} + FrameOverhead;

  always_comb begin
    count_d         = count_q;
    len_d           = len_q;
    res_o.status    = ST_ACCEPT;
    res_o.data_byte = rx_byte_i;
    res_o.position  = count_q;
    case (count_q)
      PosStart: begin
        if (rx_byte_i == cfg_i.sof_byte) begin
          count_d = PosOpcode;
        end else begin
          res_o.status = ST_DISCARD;
        end
      end
      PosOpcode: begin
        count_d = PosLength;
      end
      PosLength: begin
        if (frame_size > cfg_i.max_frame_bytes) begin
          res_o.status = ST_BAD_LEN;
          count_d      = PosStart;
          len_d        = '0;
        end else begin
          len_d   = rx_byte_i;
          count_d = PosLength + 9'd1;
        end
      end
      default: begin
        if (count_q >= last_pos) begin
          res_o.status = (rx_byte_i == cfg_i.eof_byte) ? ST_DONE : ST_BAD_END;
          count_d      = PosStart;
          len_d        = '0;
        end else begin
          count_d = count_q + 9'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      len_q   <= len_d;
    end
  end

endmodule

// ----- rtl/flag_delimited_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// flag_delimited_frame_receiver
// Hunts for start flag framed packets and reports every received byte with
// its frame offset and a status code.
// ----------------------------------------------------------------------------
// result: registered, shown in the cycle after its input word is accepted
// throughput: 1 word per cycle while the output is not stalled, set by the single result register
// input stalls only while a result is held and the output is stalled
// reset: registers take their default flags and maximum, receiver hunts
module flag_delimited_frame_receiver
  import ffr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [PosW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatW-1:0]   status_o,
  output logic [ByteW-1:0]   data_byte_o,
  output logic [PosW-1:0]    position_o
);

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic in_accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sof_byte        <= StartFlagRst;
      cfg_q.eof_byte        <= EndFlagRst;
      cfg_q.max_frame_bytes <= MaxFrameRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStartFlag: cfg_q.sof_byte        <= cfg_wdata_i[ByteW-1:0];
        RegEndFlag:   cfg_q.eof_byte        <= cfg_wdata_i[ByteW-1:0];
        RegMaxFrame:  cfg_q.max_frame_bytes <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ffr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign data_byte_o = res_q.data_byte;
  assign position_o  = res_q.position;

endmodule

// ----- rtl/ffr_checker.sv -----
// ----------------------------------------------------------------------------
// ffr_checker
// Port level checks for the flag delimited frame receiver.
// ----------------------------------------------------------------------------
module ffr_checker
  import ffr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [ByteW-1:0]   rx_byte_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [StatW-1:0]   status_o,
  input logic [ByteW-1:0]   data_byte_o,
  input logic [PosW-1:0]    position_o
);

  // held word stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // accepted word shows up next cycle with the echoed byte
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o && data_byte_o == $past(rx_byte_i))
    else $error("accepted word not echoed");

  // discarded hunting words sit at offset zero
  a_discard_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DISCARD |-> position_o == PosStart)
    else $error("discarded word with nonzero offset");

  // length abort only on the length byte
  a_bad_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_LEN |-> position_o == PosLength)
    else $error("length abort at wrong offset");

  // frame end only past the header
  a_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_DONE || status_o == ST_BAD_END) |->
      position_o > PosLength && position_o <= PosMax)
    else $error("frame end at impossible offset");

endmodule

bind flag_delimited_frame_receiver ffr_checker u_ffr_checker (.*);

// ----- verif/flag_delimited_frame_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// flag_delimited_frame_receiver_tb
// Drives byte streams of well formed, truncated, oversized and badly closed
// frames through the receiver under several flag and size settings, with
// random gaps and output stalls. A scoreboard tracks the frame offset and
// length on its own and checks status, echoed byte and position of every
// output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flag_delimited_frame_receiver_tb
  import ffr_pkg::*;
();

  localparam logic [RegIdxW-1:0] RegUnused = 2'd3;
  localparam int IdlePct    = 19;
  localparam int HoldCycles = 60;
  localparam int QuietLimit = 1000;
  localparam int PhaseItems = 200;

  class frame_scoreboard;
    cfg_t            cfg;
    logic [PosW-1:0]  byte_count;
    logic [ByteW-1:0] payload_length;
    res_t            expected_words[$];
    int              errors;

    function new();
      cfg.sof_byte        = StartFlagRst;
      cfg.eof_byte        = EndFlagRst;
      cfg.max_frame_bytes = MaxFrameRst;
      byte_count          = PosStart;
      payload_length      = '0;
      errors              = 0;
    endfunction

    function void write_reg(input logic [RegIdxW-1:0] idx, input logic [PosW-1:0] val);
      case (idx)
        RegStartFlag: cfg.sof_byte = val[ByteW-1:0];
        RegEndFlag:   cfg.eof_byte = val[ByteW-1:0];
        RegMaxFrame:  cfg.max_frame_bytes = val;
        default: ;
      endcase
    endfunction

    function void note_rx_byte(input logic [ByteW-1:0] b);
      res_t w;
      int   last;
      w.data_byte = b;
      w.position  = byte_count;
      if (byte_count == PosStart) begin
        if (b == cfg.sof_byte) begin
          w.status   = ST_ACCEPT;
          byte_count = PosOpcode;
        end else begin
          w.status = ST_DISCARD;
        end
      end else if (byte_count == PosOpcode) begin
        w.status   = ST_ACCEPT;
        byte_count = PosLength;
      end else if (byte_count == PosLength) begin
        if (int'(b) + int'(FrameOverhead) > int'(cfg.max_frame_bytes)) begin
          w.status       = ST_BAD_LEN;
          byte_count     = PosStart;
          payload_length = '0;
        end else begin
          w.status       = ST_ACCEPT;
          payload_length = b;
          byte_count     = PosLength + 1'b1;
        end
      end else begin
        last = int'(payload_length) + int'(FrameOverhead) - 1;
        if (int'(byte_count) >= last) begin
          w.status       = (b == cfg.eof_byte) ? ST_DONE : ST_BAD_END;
          byte_count     = PosStart;
          payload_length = '0;
        end else begin
          w.status   = ST_ACCEPT;
          byte_count = byte_count + 1'b1;
        end
      end
      expected_words.push_back(w);
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_output_word(input logic [StatW-1:0] st, input logic [ByteW-1:0] d,
                           input logic [PosW-1:0] p);
      res_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d byte %02h position %0d",
                                  st, d, p));
        return;
      end
      want = expected_words.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %s (byte %02h position %0d)",
                                  st, want.status.name(), want.data_byte, want.position));
      if (d !== want.data_byte)
        report_mismatch($sformatf("data byte %02h, want %02h", d, want.data_byte));
      if (p !== want.position)
        report_mismatch($sformatf("position %0d, want %0d (byte %02h)",
                                  p, want.position, want.data_byte));
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i   = RegStartFlag;
  logic [PosW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [StatW-1:0]   status_o;
  logic [ByteW-1:0]   data_byte_o;
  logic [PosW-1:0]    position_o;

  frame_scoreboard sb = new();
  bit idle_on         = 1'b1;
  int holds_requested = 0;
  int holds_done      = 0;
  int items_sent      = 0;
  int quiet_cycles    = 0;

  flag_delimited_frame_receiver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_byte_o (data_byte_o),
    .position_o  (position_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // word monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_rx_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i)
        sb.check_output_word(status_o, data_byte_o, position_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver side: random stalls plus requested long hold-offs
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_requested) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < IdlePct);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while (idle_on && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_frame(input int len, input bit good_end, input int keep);
    logic [ByteW-1:0] frame_q[$];
    frame_q.push_back(sb.cfg.sof_byte);
    frame_q.push_back(ByteW'($urandom));
    frame_q.push_back(ByteW'(len));
    repeat (len) frame_q.push_back(ByteW'($urandom));
    frame_q.push_back(ByteW'($urandom));
    frame_q.push_back(good_end ? sb.cfg.eof_byte : ByteW'($urandom));
    for (int i = 0; i < keep && i < frame_q.size(); i++) send_byte(frame_q[i]);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [PosW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // only between phases, once every output word is back
  task automatic set_config(input logic [ByteW-1:0] sflag, input logic [ByteW-1:0] eflag,
                            input logic [PosW-1:0] max_bytes);
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    write_reg(RegUnused, PosW'($urandom));
    write_reg(RegStartFlag, {1'($urandom), sflag});
    write_reg(RegEndFlag, {1'($urandom), eflag});
    write_reg(RegMaxFrame, max_bytes);
  endtask

  task automatic run_random(input int quota);
    int target;
    int pick;
    int len;
    int lim;
    target = items_sent + quota;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      lim  = int'(sb.cfg.max_frame_bytes) - int'(FrameOverhead);
      if (pick < 8) begin
        send_byte(ByteW'($urandom));
      end else if (pick < 14) begin
        len = $urandom_range(0, 10);
        send_frame(len, 1'b1, $urandom_range(1, len + 4));
      end else begin
        if (lim >= 0 && lim <= 255 && $urandom_range(19) == 0) begin
          len = lim + $urandom_range(0, 1);
          if (len > 255) len = 255;
        end else if ($urandom_range(24) == 0) begin
          len = $urandom_range(0, 255);
        end else begin
          len = $urandom_range(0, 10);
        end
        if (len > lim) begin
          send_frame(len, 1'b1, 3);
        end else begin
          send_frame(len, $urandom_range(9) != 0, len + 5);
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunting bytes at both extremes
    send_byte(8'h00);
    send_byte(8'hff);
    // empty frame, good close
    send_byte(StartFlagRst);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(EndFlagRst);
    // one data byte, bad close with a start flag value
    send_byte(StartFlagRst);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(StartFlagRst);
    // length one past the limit, then a restart right after
    send_byte(StartFlagRst);
    send_byte(8'h7f);
    send_byte(8'd196);
    send_byte(StartFlagRst);
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(EndFlagRst);

    holds_requested++;
    run_random(PhaseItems);

    set_config(8'h7e, 8'h7e, 9'd260);
    run_random(PhaseItems);
    set_config(8'h00, 8'hff, 9'd5);
    run_random(PhaseItems);

    idle_on = 1'b0;
    set_config(8'hff, 8'h00, 9'd261);
    run_random(PhaseItems);
    idle_on = 1'b1;

    set_config(ByteW'($urandom), ByteW'($urandom), PosW'($urandom_range(5, 40)));
    holds_requested++;
    run_random(PhaseItems);
    set_config(StartFlagRst, EndFlagRst, 9'd4);
    run_random(PhaseItems);
    set_config(ByteW'($urandom), ByteW'($urandom), 9'd511);
    run_random(PhaseItems);
    set_config(ByteW'($urandom), ByteW'($urandom), 9'd0);
    run_random(PhaseItems);
    set_config(StartFlagRst, EndFlagRst, MaxFrameRst);
    run_random(PhaseItems);

    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
